FILE: sv/rra_pkg.sv
// Shared types and constants for the range reservation admission block.
`default_nettype none

package rra_pkg;

    localparam int NUM_SLOTS  = 1024;
    localparam int SLOT_W     = 11;
    localparam int CAP_W      = 30;
    localparam int NUM_W      = 20;
    localparam int ADDR_W     = $clog2(NUM_SLOTS);
    localparam logic [NUM_W-1:0] MAX_ORDERS = NUM_W'(1048575);

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_ORDER,
        OP_SKIP
    } t_op;

    typedef enum logic [1:0] {
        CLS_PASS,
        CLS_FAIL,
        CLS_SCAN
    } t_cls;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TAKE,
        ST_REPLY
    } t_state;

    // One classified word from the front end. For a load, lo holds the slot
    // address and value the capacity; for an order, value is the amount.
    typedef struct packed {
        t_op               op;
        t_cls              cls;
        logic [NUM_W-1:0]  number;
        logic [CAP_W-1:0]  value;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
    } t_cmd;

endpackage

`default_nettype wire

FILE: sv/rra_front.sv
// Front end: numbers orders and classifies each input word into a command.
`default_nettype none

module rra_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic                      i_kind,
    input  wire logic [rra_pkg::SLOT_W-1:0] i_slot,
    input  wire logic [rra_pkg::CAP_W-1:0]  i_capacity,
    input  wire logic [rra_pkg::CAP_W-1:0]  i_amount,
    input  wire logic [rra_pkg::SLOT_W-1:0] i_first_slot,
    input  wire logic [rra_pkg::SLOT_W-1:0] i_last_slot,
    output rra_pkg::t_cmd                   o_cmd
);
    import rra_pkg::*;

    logic [NUM_W-1:0] r_order_count;
    logic [NUM_W-1:0] n_order_count;
    logic             slot_ok;
    logic             lo_bad;
    logic             hi_bad;

    assign slot_ok = (i_slot != '0) && (i_slot <= SLOT_W'(NUM_SLOTS));
    assign lo_bad  = (i_first_slot == '0);
    assign hi_bad  = (i_last_slot > SLOT_W'(NUM_SLOTS));

    always_comb begin
        n_order_count = r_order_count;
        o_cmd.op      = OP_SKIP;
        o_cmd.cls     = CLS_PASS;
        o_cmd.number  = '0;
        o_cmd.value   = i_amount;
        o_cmd.lo      = ADDR_W'(i_first_slot - SLOT_W'(1));
        o_cmd.hi      = ADDR_W'(i_last_slot - SLOT_W'(1));
        if (!i_kind) begin
            if (slot_ok) begin
                o_cmd.op = OP_LOAD;
            end
            o_cmd.value = i_capacity;
            o_cmd.lo    = ADDR_W'(i_slot - SLOT_W'(1));
        end else if (r_order_count < MAX_ORDERS) begin
            n_order_count = r_order_count + NUM_W'(1);
            o_cmd.op      = OP_ORDER;
            o_cmd.number  = n_order_count;
            // A reversed range or a zero amount always fits and changes nothing.
            if (i_first_slot > i_last_slot || i_amount == '0) begin
                o_cmd.cls = CLS_PASS;
            end else if (lo_bad || hi_bad) begin
                o_cmd.cls = CLS_FAIL;
            end else begin
                o_cmd.cls = CLS_SCAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_count <= '0;
        end else if (i_accept) begin
            r_order_count <= n_order_count;
        end
    end

endmodule

`default_nettype wire

FILE: sv/rra_cmd_q.sv
// Two-entry command queue between the front end and the back end.
`default_nettype none

module rra_cmd_q (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire rra_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_valid,
    output rra_pkg::t_cmd      o_cmd,
    input  wire logic          i_pop
);
    import rra_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: sv/rra_back.sv
// Back end: capacity memory, check and take passes, and the result register.
`default_nettype none

module rra_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire rra_pkg::t_cmd             i_cmd,
    output logic                           o_pop,
    output logic                           o_empty,
    input  wire logic                      i_res_pop,
    output logic                           o_granted,
    output logic [rra_pkg::NUM_W-1:0]      o_order_number,
    output logic [rra_pkg::NUM_W-1:0]      o_first_failed
);
    import rra_pkg::*;

    logic [CAP_W-1:0] r_mem [NUM_SLOTS];

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic              r_issued, n_issued;
    logic              r_rd_vld, n_rd_vld;
    logic [ADDR_W-1:0] r_rd_addr;
    logic [CAP_W-1:0]  r_rd_data;
    logic              r_ok, n_ok;
    logic              r_granted, n_granted;
    logic [NUM_W-1:0]  r_number, n_number;
    logic [NUM_W-1:0]  r_failed, n_failed;
    logic              r_out_vld, n_out_vld;
    logic              r_out_granted, n_out_granted;
    logic [NUM_W-1:0]  r_out_number, n_out_number;
    logic [NUM_W-1:0]  r_out_failed, n_out_failed;

    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CAP_W-1:0]  wr_data;
    logic              pass_done;

    assign o_empty        = !r_out_vld;
    assign o_granted      = r_out_granted;
    assign o_order_number = r_out_number;
    assign o_first_failed = r_out_failed;
    assign pass_done      = r_issued && !r_rd_vld;

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_ptr         = r_ptr;
        n_issued      = r_issued;
        n_ok          = r_ok;
        n_granted     = r_granted;
        n_number      = r_number;
        n_failed      = r_failed;
        n_out_vld     = r_out_vld && !i_res_pop;
        n_out_granted = r_out_granted;
        n_out_number  = r_out_number;
        n_out_failed  = r_out_failed;
        o_pop         = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = r_rd_addr;
        wr_data       = r_rd_data - r_cmd.value;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_pop     = 1'b1;
                    n_cmd     = i_cmd;
                    n_granted = 1'b0;
                    n_number  = i_cmd.number;
                    n_ptr     = i_cmd.lo;
                    n_issued  = 1'b0;
                    n_ok      = 1'b1;
                    n_state   = ST_REPLY;
                    if (i_cmd.op == OP_LOAD) begin
                        wr_en   = 1'b1;
                        wr_addr = i_cmd.lo;
                        wr_data = i_cmd.value;
                    end else if (i_cmd.op == OP_ORDER && r_failed == '0) begin
                        case (i_cmd.cls)
                            CLS_PASS: n_granted = 1'b1;
                            CLS_FAIL: n_failed  = i_cmd.number;
                            default:  n_state   = ST_CHECK;
                        endcase
                    end
                end
            end
            ST_CHECK: begin
                rd_en = !r_issued;
                if (r_rd_vld && r_rd_data < r_cmd.value) begin
                    n_ok = 1'b0;
                end
                if (pass_done) begin
                    if (r_ok) begin
                        n_ptr    = r_cmd.lo;
                        n_issued = 1'b0;
                        n_state  = ST_TAKE;
                    end else begin
                        n_failed = r_cmd.number;
                        n_state  = ST_REPLY;
                    end
                end
            end
            ST_TAKE: begin
                // Read one slot while the slot read in the last cycle is written back.
                rd_en = !r_issued;
                wr_en = r_rd_vld;
                if (pass_done) begin
                    n_granted = 1'b1;
                    n_state   = ST_REPLY;
                end
            end
            ST_REPLY: begin
                if (!r_out_vld || i_res_pop) begin
                    n_out_vld     = 1'b1;
                    n_out_granted = r_granted;
                    n_out_number  = r_number;
                    n_out_failed  = r_failed;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (rd_en) begin
            if (r_ptr == r_cmd.hi) begin
                n_issued = 1'b1;
            end else begin
                n_ptr = r_ptr + ADDR_W'(1);
            end
        end
        n_rd_vld = rd_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_failed  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_failed  <= n_failed;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_ptr         <= n_ptr;
        r_issued      <= n_issued;
        r_ok          <= n_ok;
        r_granted     <= n_granted;
        r_number      <= n_number;
        r_out_granted <= n_out_granted;
        r_out_number  <= n_out_number;
        r_out_failed  <= n_out_failed;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_ptr];
            r_rd_addr <= r_ptr;
        end
    end

endmodule

`default_nettype wire

FILE: sv/range_reservation_admission_top.sv
// Top level of the first-come range capacity reservation block.
`default_nettype none

// Channel   Handshake             Fields
// input     push / full           i_kind, i_slot, i_capacity, i_amount,
//                                 i_first_slot, i_last_slot
// result    empty / pop           o_granted, o_order_number, o_first_failed
//
// A load, a skipped word or an order decided without a scan goes from idle straight to
// the reply state in the back end. A scanned order uses the single read port of the
// capacity memory for one check pass and, if every slot has room, one take pass.
// The two-entry command queue lets up to two words be taken while the back end works.
// Reset clears the order count and the first-failed number; capacities hold garbage
// until loaded.

module range_reservation_admission_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic                       i_kind,
    input  wire logic [rra_pkg::SLOT_W-1:0] i_slot,
    input  wire logic [rra_pkg::CAP_W-1:0]  i_capacity,
    input  wire logic [rra_pkg::CAP_W-1:0]  i_amount,
    input  wire logic [rra_pkg::SLOT_W-1:0] i_first_slot,
    input  wire logic [rra_pkg::SLOT_W-1:0] i_last_slot,
    output logic                            empty,
    input  wire logic                       pop,
    output logic                            o_granted,
    output logic [rra_pkg::NUM_W-1:0]       o_order_number,
    output logic [rra_pkg::NUM_W-1:0]       o_first_failed
);
    import rra_pkg::*;

    t_cmd front_cmd;
    t_cmd q_cmd;
    logic q_valid;
    logic q_pop;
    logic accept;

    assign accept = push && !full;

    rra_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_kind       (i_kind),
        .i_slot       (i_slot),
        .i_capacity   (i_capacity),
        .i_amount     (i_amount),
        .i_first_slot (i_first_slot),
        .i_last_slot  (i_last_slot),
        .o_cmd        (front_cmd)
    );

    rra_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    rra_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_cmd          (q_cmd),
        .o_pop          (q_pop),
        .o_empty        (empty),
        .i_res_pop      (pop),
        .o_granted      (o_granted),
        .o_order_number (o_order_number),
        .o_first_failed (o_first_failed)
    );

endmodule

`default_nettype wire
